@@ rtl/fteval_pkg.sv @@
package fteval_pkg;

  // Operand width and operator codes on the input side
  localparam int W = 64;
  localparam int OPC_W = 3;
  localparam logic [OPC_W-1:0] OPC_ADD = 3'd0;
  localparam logic [OPC_W-1:0] OPC_SUB = 3'd1;
  localparam logic [OPC_W-1:0] OPC_MUL = 3'd2;
  localparam logic [OPC_W-1:0] OPC_DIV = 3'd3;

  localparam int FTE_QUEUE_DEPTH = 4;

  typedef enum logic [1:0] {
    KIND_ADD,
    KIND_SUB,
    KIND_MUL,
    KIND_DIV
  } kind_t;

  typedef struct packed {
    logic signed [W-1:0]     operand_first;
    logic signed [W-1:0]     operand_second;
    logic signed [W-1:0]     operand_third;
    logic signed [W-1:0]     operand_fourth;
    logic        [OPC_W-1:0] op_first;
    logic        [OPC_W-1:0] op_second;
    logic        [OPC_W-1:0] op_third;
  } fteval_in_t;

  typedef struct packed {
    logic signed [W-1:0] value;
    logic                error;
  } fteval_out_t;

  // Classified item: operands by position, decoded operators, bad-code flag
  typedef struct packed {
    logic  [3:0][W-1:0] opnd;
    kind_t [2:0]        kind;
    logic               bad;
  } cls_t;

  // Running evaluation state: settled sum, pending sign, open product term
  typedef struct packed {
    cls_t         cls;
    logic [W-1:0] sum;
    logic         sum_sub;
    logic [W-1:0] prod;
    logic         fault;
  } acc_t;

  // Signed add or subtract; top bit flags overflow
  function automatic logic [W:0] add_chk(logic [W-1:0] a, logic [W-1:0] b, logic sub);
    logic [W:0] s;
    s = sub ? ({a[W-1], a} - {b[W-1], b}) : ({a[W-1], a} + {b[W-1], b});
    return {s[W] ^ s[W-1], s[W-1:0]};
  endfunction

endpackage

@@ rtl/fteval_front.sv @@
module fteval_front
  import fteval_pkg::*;
(
  input  fteval_in_t item,
  output cls_t       cls
);

  logic [2:0][OPC_W-1:0] codes;

  assign codes = {item.op_third, item.op_second, item.op_first};

  // Decode operators and gather operands by position
  always_comb begin
    cls = '0;
    cls.opnd[0] = item.operand_first;
    cls.opnd[1] = item.operand_second;
    cls.opnd[2] = item.operand_third;
    cls.opnd[3] = item.operand_fourth;
    for (int k = 0; k < 3; k++) begin
      case (codes[k])
        OPC_ADD: cls.kind[k] = KIND_ADD;
        OPC_SUB: cls.kind[k] = KIND_SUB;
        OPC_MUL: cls.kind[k] = KIND_MUL;
        OPC_DIV: cls.kind[k] = KIND_DIV;
        default: begin
          cls.kind[k] = KIND_ADD;
          cls.bad = 1'b1;
        end
      endcase
    end
  end

endmodule

@@ rtl/fteval_queue.sv @@
module fteval_queue
  import fteval_pkg::*;
#(
  parameter int DEPTH = FTE_QUEUE_DEPTH
) (
  input  logic clk,
  input  logic rst,
  input  logic push,
  input  cls_t wdata,
  output logic full,
  input  logic pop,
  output cls_t rdata,
  output logic empty
);

  localparam int PW = $clog2(DEPTH);
  localparam int CW = $clog2(DEPTH + 1);
  localparam logic [PW-1:0] LAST = PW'(DEPTH - 1);

  cls_t          mem [DEPTH];
  logic [PW-1:0] wptr;
  logic [PW-1:0] rptr;
  logic [CW-1:0] cnt;
  logic          do_push;
  logic          do_pop;

  assign full    = (cnt == CW'(DEPTH));
  assign empty   = (cnt == '0);
  assign do_push = push && !full;
  assign do_pop  = pop && !empty;
  assign rdata   = mem[rptr];

  // Store incoming entries
  always_ff @(posedge clk) begin
    if (do_push) begin
      mem[wptr] <= wdata;
    end
  end

  // Advance pointers and occupancy
  always_ff @(posedge clk) begin
    if (rst) begin
      wptr <= '0;
      rptr <= '0;
      cnt  <= '0;
    end else begin
      if (do_push) begin
        wptr <= (wptr == LAST) ? '0 : wptr + 1'b1;
      end
      if (do_pop) begin
        rptr <= (rptr == LAST) ? '0 : rptr + 1'b1;
      end
      if (do_push && !do_pop) begin
        cnt <= cnt + 1'b1;
      end else if (do_pop && !do_push) begin
        cnt <= cnt - 1'b1;
      end
    end
  end

endmodule

@@ rtl/fteval_step.sv @@
module fteval_step
  import fteval_pkg::*;
(
  input  logic         clk,
  input  logic         rst,
  input  logic         en,
  input  logic         in_valid,
  input  acc_t         in_acc,
  input  logic [W-1:0] x,
  input  kind_t        kind,
  output logic         out_valid,
  output acc_t         out_acc
);

  localparam int H = W / 2;

  typedef struct packed {
    acc_t             acc;
    logic             is_md;
    logic             is_div;
    logic             aneg;
    logic             bneg;
    logic [W-1:0]     amag;
    logic [W-1:0]     bmag;
    logic [W:0]       rem;
    logic [W-1:0]     quo;
    logic [3:0][W-1:0] pp;
    logic [W:0]       mid;
    logic [2*W-1:0]   pmag;
  } md_t;

  md_t        s0;
  md_t        pipe [W+1];
  md_t        nxt  [W+1];
  logic [W:0] pv;
  acc_t       fin;

  // Fold add/sub into the sum, or set up the multiply/divide operands
  always_comb begin
    logic       addsub;
    logic [W:0] chk;
    addsub = (kind == KIND_ADD) || (kind == KIND_SUB);
    chk    = add_chk(in_acc.sum, in_acc.prod, in_acc.sum_sub);
    s0        = '0;
    s0.acc    = in_acc;
    s0.is_md  = !addsub;
    s0.is_div = (kind == KIND_DIV);
    s0.aneg   = in_acc.prod[W-1];
    s0.bneg   = x[W-1];
    s0.amag   = in_acc.prod[W-1] ? -in_acc.prod : in_acc.prod;
    s0.bmag   = x[W-1] ? -x : x;
    if (addsub) begin
      s0.acc.sum     = chk[W-1:0];
      s0.acc.sum_sub = (kind == KIND_SUB);
      s0.acc.prod    = x;
      s0.acc.fault   = in_acc.fault | chk[W];
    end
  end

  assign nxt[0] = s0;

  // One quotient bit per stage; the multiply rides in the first three stages
  for (genvar i = 1; i <= W; i++) begin : g_stage
    always_comb begin
      logic [W:0] rsh;
      nxt[i] = pipe[i-1];
      rsh = {pipe[i-1].rem[W-1:0], pipe[i-1].amag[W-i]};
      if (rsh >= {1'b0, pipe[i-1].bmag}) begin
        rsh = rsh - {1'b0, pipe[i-1].bmag};
        nxt[i].quo[W-i] = 1'b1;
      end
      nxt[i].rem = rsh;
      if (i == 1) begin
        nxt[i].pp[0] = W'(pipe[i-1].amag[H-1:0] * pipe[i-1].bmag[H-1:0]);
        nxt[i].pp[1] = W'(pipe[i-1].amag[H-1:0] * pipe[i-1].bmag[W-1:H]);
        nxt[i].pp[2] = W'(pipe[i-1].amag[W-1:H] * pipe[i-1].bmag[H-1:0]);
        nxt[i].pp[3] = W'(pipe[i-1].amag[W-1:H] * pipe[i-1].bmag[W-1:H]);
      end else if (i == 2) begin
        nxt[i].mid = {1'b0, pipe[i-1].pp[1]} + {1'b0, pipe[i-1].pp[2]};
      end else if (i == 3) begin
        nxt[i].pmag = {pipe[i-1].pp[3], pipe[i-1].pp[0]}
                    + ((2*W)'(pipe[i-1].mid) << H);
        nxt[i].pp   = '0;
        nxt[i].mid  = '0;
      end
    end
  end

  // Advance the stage registers together
  for (genvar i = 0; i <= W; i++) begin : g_reg
    always_ff @(posedge clk) begin
      if (rst) begin
        pv[i] <= 1'b0;
      end else if (en) begin
        pv[i] <= (i == 0) ? in_valid : pv[(i == 0) ? 0 : i-1];
      end
      if (en) begin
        pipe[i] <= nxt[i];
      end
    end
  end

  // Sign-fix, check range and pick the new product term
  always_comb begin
    logic         mneg;
    logic         qneg;
    logic         movf;
    logic         dovf;
    logic [W-1:0] mres;
    logic [W-1:0] dres;
    mneg = pipe[W].aneg ^ pipe[W].bneg;
    qneg = mneg;
    movf = mneg ? ((pipe[W].pmag[2*W-1:W] != '0) ||
                   (pipe[W].pmag[W-1] && (pipe[W].pmag[W-2:0] != '0)))
                : (pipe[W].pmag[2*W-1:W-1] != '0);
    mres = mneg ? -pipe[W].pmag[W-1:0] : pipe[W].pmag[W-1:0];
    dovf = (pipe[W].bmag == '0) || (!qneg && pipe[W].quo[W-1]);
    dres = qneg ? -pipe[W].quo : pipe[W].quo;
    fin  = pipe[W].acc;
    if (pipe[W].is_md) begin
      if (pipe[W].is_div) begin
        fin.prod  = dres;
        fin.fault = pipe[W].acc.fault | dovf;
      end else begin
        fin.prod  = mres;
        fin.fault = pipe[W].acc.fault | movf;
      end
    end
  end

  // Hold the step result
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (en) begin
      out_valid <= pv[W];
    end
    if (en) begin
      out_acc <= fin;
    end
  end

endmodule

@@ rtl/fteval_back.sv @@
module fteval_back
  import fteval_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        q_empty,
  input  cls_t        q_item,
  output logic        q_pop,
  output fteval_out_t result,
  output logic        empty,
  input  logic        pop
);

  logic       en;
  logic       ovalid;
  acc_t       chain [4];
  logic [3:0] cv;
  logic [W:0] chk;

  // The whole pipe moves when the output slot frees up
  assign en    = !ovalid || pop;
  assign q_pop = en && !q_empty;
  assign empty = !ovalid;

  // Start with an empty sum and the first operand as the open term
  always_comb begin
    chain[0]         = '0;
    chain[0].cls     = q_item;
    chain[0].prod    = q_item.opnd[0];
    chain[0].fault   = q_item.bad;
  end
  assign cv[0] = q_pop;

  for (genvar k = 0; k < 3; k++) begin : g_step
    fteval_step u_step (
      .clk       (clk),
      .rst       (rst),
      .en        (en),
      .in_valid  (cv[k]),
      .in_acc    (chain[k]),
      .x         (chain[k].cls.opnd[k+1]),
      .kind      (chain[k].cls.kind[k]),
      .out_valid (cv[k+1]),
      .out_acc   (chain[k+1])
    );
  end

  assign chk = add_chk(chain[3].sum, chain[3].prod, chain[3].sum_sub);

  // Close the last term and hold the result for transfer
  always_ff @(posedge clk) begin
    if (rst) begin
      ovalid <= 1'b0;
    end else if (en) begin
      ovalid <= cv[3];
    end
    if (en) begin
      result.error <= chain[3].fault | chk[W];
      result.value <= (chain[3].fault | chk[W]) ? '0 : chk[W-1:0];
    end
  end

endmodule

@@ rtl/checked_four_term_expression_eval_core.sv @@
// An item passes the queue, then three step units, then the result register.
// Throughput: one item per cycle unless the output stalls; each step runs a
// 64-stage radix-2 divider with the split 32x32 multiply inside its first stages.
// The whole back pipe advances only when the output register is free or popped.
// Reset (rst, synchronous, active high) empties the queue and all pipe stages.
module checked_four_term_expression_eval_core
  import fteval_pkg::*;
#(
  parameter int QUEUE_DEPTH = FTE_QUEUE_DEPTH
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        push,
  output logic        full,
  input  fteval_in_t  item,
  output logic        empty,
  input  logic        pop,
  output fteval_out_t result
);

  cls_t cls;
  cls_t q_item;
  logic q_empty;
  logic q_pop;

  fteval_front u_front (
    .item (item),
    .cls  (cls)
  );

  fteval_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk   (clk),
    .rst   (rst),
    .push  (push),
    .wdata (cls),
    .full  (full),
    .pop   (q_pop),
    .rdata (q_item),
    .empty (q_empty)
  );

  fteval_back u_back (
    .clk     (clk),
    .rst     (rst),
    .q_empty (q_empty),
    .q_item  (q_item),
    .q_pop   (q_pop),
    .result  (result),
    .empty   (empty),
    .pop     (pop)
  );

endmodule
